// ===== src/timer_sampled_uart_transceiver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timer-sampled UART transceiver
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TIMER_SAMPLED_UART_TRANSCEIVER_ASSERT_SVH
`define TIMER_SAMPLED_UART_TRANSCEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TSUT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsut assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TSUT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsut assertion failed");

`else

`define TSUT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TSUT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/tsut_pkg.sv =====
// ----------------------------------------------------------------------------
// tsut_pkg
// Shared types and constants of the timer-sampled UART transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package tsut_pkg;

   // Timer top value after reset: one bit period is BIT_TOP_RESET + 1 ticks.
   localparam logic [7:0] BIT_TOP_RESET = 8'd103;

   // One input item: the line level and the host requests of one tick.
   typedef struct packed {
      logic       rxd;
      logic       tx_load;
      logic [7:0] tx_byte;
      logic       rx_take;
      logic       err_clear;
   } req_item_type;

   // One result item: the visible state after the tick.
   typedef struct packed {
      logic       txd;
      logic       tx_busy;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       rx_error;
      logic       rx_busy;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== src/tsut_core.sv =====
// ----------------------------------------------------------------------------
// tsut_core
// UART state for one timer tick per step: bit counter, receiver and
// transmitter. The result is the state after the step, given combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_sampled_uart_transceiver_assert.svh"

module tsut_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire tsut_pkg::req_item_type item,
   input  wire logic [7:0]            bit_top,
   output tsut_pkg::rsp_item_type     result
);

   // Receive and transmit step numbers.
   localparam logic [3:0] RX_STEP_START      = 4'd1;
   localparam logic [3:0] RX_STEP_FIRST_DATA = 4'd2;
   localparam logic [3:0] RX_STEP_LAST_DATA  = 4'd9;
   localparam logic [3:0] RX_STEP_STORE      = 4'd10;
   localparam logic [3:0] TX_STEP_START      = 4'd1;
   localparam logic [3:0] TX_STEP_FIRST_DATA = 4'd2;
   localparam logic [3:0] TX_STEP_LAST_DATA  = 4'd9;
   localparam logic [3:0] TX_STEP_STOP       = 4'd10;
   localparam logic [3:0] TX_STEP_LAST       = 4'd11;

   logic [7:0] bit_timer_ff,    bit_timer_in;
   logic       prev_rx_ff,      prev_rx_in;
   logic       rx_active_ff,    rx_active_in;
   logic [3:0] rx_step_ff,      rx_step_in;
   logic [7:0] sample_point_ff, sample_point_in;
   logic [7:0] rx_shift_ff,     rx_shift_in;
   logic [7:0] rx_held_ff,      rx_held_in;
   logic       rx_pending_ff,   rx_pending_in;
   logic       error_ff,        error_in;
   logic       tx_active_ff,    tx_active_in;
   logic [3:0] tx_step_ff,      tx_step_in;
   logic [7:0] tx_shift_ff,     tx_shift_in;
   logic       line_out_ff,     line_out_in;

   logic [7:0] half;
   logic [2:0] rx_bit_idx;
   logic [2:0] tx_bit_idx;
   logic       count_up;
   logic [7:0] timer_plus1;

   assign half = {1'b0, bit_top[7:1]};

   // Next state of one tick. All tests use the counter value at entry.
   always_comb begin
      bit_timer_in    = bit_timer_ff;
      prev_rx_in      = item.rxd;
      rx_active_in    = rx_active_ff;
      rx_step_in      = rx_step_ff;
      sample_point_in = sample_point_ff;
      rx_shift_in     = rx_shift_ff;
      rx_held_in      = rx_held_ff;
      rx_pending_in   = rx_pending_ff;
      error_in        = error_ff;
      tx_active_in    = tx_active_ff;
      tx_step_in      = tx_step_ff;
      tx_shift_in     = tx_shift_ff;
      line_out_in     = line_out_ff;
      rx_bit_idx      = 3'd0;
      tx_bit_idx      = 3'd0;

      // Host requests are applied before the receiver runs.
      if (item.err_clear) begin
         error_in = 1'b0;
      end
      if (item.rx_take) begin
         rx_pending_in = 1'b0;
      end

      // Receiver: sample at the sample point, or arm on a line change.
      if (rx_active_ff) begin
         if (bit_timer_ff == sample_point_ff) begin
            rx_step_in = rx_step_ff + 4'd1;
            rx_bit_idx = 3'(rx_step_in - RX_STEP_FIRST_DATA);
            if (rx_step_in == RX_STEP_START) begin
               rx_shift_in = 8'd0;
               if (item.rxd) begin
                  // A high start bit was a glitch: drop the frame.
                  rx_active_in = 1'b0;
               end else begin
                  if (rx_pending_in) begin
                     error_in = 1'b1;
                  end
                  rx_pending_in = 1'b0;
               end
            end else if (rx_step_in >= RX_STEP_FIRST_DATA &&
                         rx_step_in <= RX_STEP_LAST_DATA) begin
               rx_shift_in[rx_bit_idx] = rx_shift_ff[rx_bit_idx] | item.rxd;
            end else begin
               if (rx_step_in == RX_STEP_STORE) begin
                  rx_held_in    = rx_shift_ff;
                  rx_pending_in = 1'b1;
               end
               rx_active_in = 1'b0;
            end
         end
      end else if (item.rxd != prev_rx_ff) begin
         rx_active_in = 1'b1;
         rx_step_in   = 4'd0;
         if (bit_timer_ff >= half) begin
            sample_point_in = bit_timer_ff - half;
         end else begin
            sample_point_in = bit_timer_ff + half;
         end
      end

      // Transmitter: one step at each counter zero.
      if (tx_active_ff && bit_timer_ff == 8'd0) begin
         tx_step_in = tx_step_ff + 4'd1;
         tx_bit_idx = 3'(tx_step_in - TX_STEP_FIRST_DATA);
         if (tx_step_in == TX_STEP_START) begin
            line_out_in = 1'b0;
         end else if (tx_step_in >= TX_STEP_FIRST_DATA &&
                      tx_step_in <= TX_STEP_LAST_DATA) begin
            line_out_in = tx_shift_ff[tx_bit_idx];
         end else if (tx_step_in == TX_STEP_STOP) begin
            line_out_in = 1'b1;
         end else begin
            tx_active_in = 1'b0;
         end
      end

      // A load is taken only when the transmitter is idle after this tick.
      if (item.tx_load && !tx_active_in) begin
         tx_shift_in  = item.tx_byte;
         tx_step_in   = 4'd0;
         tx_active_in = 1'b1;
      end

      // Free-running bit counter.
      if (bit_timer_ff >= bit_top) begin
         bit_timer_in = 8'd0;
      end else begin
         bit_timer_in = bit_timer_ff + 8'd1;
      end
   end

   // State registers advance once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_timer_ff    <= 8'd0;
         prev_rx_ff      <= 1'b1;
         rx_active_ff    <= 1'b0;
         rx_step_ff      <= 4'd0;
         sample_point_ff <= 8'd0;
         rx_shift_ff     <= 8'd0;
         rx_held_ff      <= 8'd0;
         rx_pending_ff   <= 1'b0;
         error_ff        <= 1'b0;
         tx_active_ff    <= 1'b0;
         tx_step_ff      <= 4'd0;
         tx_shift_ff     <= 8'd0;
         line_out_ff     <= 1'b1;
      end else if (step_en) begin
         bit_timer_ff    <= bit_timer_in;
         prev_rx_ff      <= prev_rx_in;
         rx_active_ff    <= rx_active_in;
         rx_step_ff      <= rx_step_in;
         sample_point_ff <= sample_point_in;
         rx_shift_ff     <= rx_shift_in;
         rx_held_ff      <= rx_held_in;
         rx_pending_ff   <= rx_pending_in;
         error_ff        <= error_in;
         tx_active_ff    <= tx_active_in;
         tx_step_ff      <= tx_step_in;
         tx_shift_ff     <= tx_shift_in;
         line_out_ff     <= line_out_in;
      end
   end

   // The result shows the state after this tick.
   always_comb begin
      result.txd      = line_out_in;
      result.tx_busy  = tx_active_in;
      result.rx_valid = rx_pending_in;
      result.rx_data  = rx_held_in;
      result.rx_error = error_in;
      result.rx_busy  = rx_active_in;
   end

   // A tick below the top value moves the counter up by one.
   assign count_up    = step_en && (bit_timer_ff < bit_top);
   assign timer_plus1 = bit_timer_ff + 8'd1;

   // The line rests high whenever no frame is being sent.
   `TSUT_ASSERT_IMPL(a_tx_idle_high, clock, reset, !tx_active_ff, line_out_ff)
   // Step counters never run past their last step.
   `TSUT_ASSERT_IMPL(a_rx_step_range, clock, reset, 1'b1, rx_step_ff <= RX_STEP_STORE)
   `TSUT_ASSERT_IMPL(a_tx_step_range, clock, reset, 1'b1, tx_step_ff <= TX_STEP_LAST)
   // Below the top value the counter advances by one per tick.
   `TSUT_ASSERT_NEXT(a_timer_count, clock, reset, count_up, bit_timer_ff == $past(timer_plus1))

endmodule

`default_nettype wire

// ===== src/timer_sampled_uart_transceiver.sv =====
// ----------------------------------------------------------------------------
// timer_sampled_uart_transceiver
// Timer-sampled 8N1 UART: one input item per timer tick, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item per timer tick: the sampled receive
//   level and the host requests (load a byte, take the received byte, clear
//   the error flag). For every accepted item the rsp_ channel returns one item
//   with the transmit line level and the receiver and transmitter status as
//   they stand after that tick.
//   An item is held in an input register and is worked when the result register
//   is free; its result is then offered from the result register. One item is
//   accepted every cycle while req_stall is low; the rate is set by the single
//   input register feeding the result register.
//   The bit period is written through csr_wr_en / csr_wr_data; the user must
//   write it only while no item is in flight, as the block does not enforce
//   this. One bit period is the written value plus one ticks. Reset clears both
//   registers, idles the receiver and transmitter, drives the line high and sets
//   the timer top to 103. While rsp_stall is high the result is held; the input
//   register holds the next item and req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_sampled_uart_transceiver (
   input  wire logic       clock,
   input  wire logic       reset,
   // Configuration
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   // Input channel
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_rxd,
   input  wire logic       req_tx_load,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_rx_take,
   input  wire logic       req_err_clear,
   // Result channel
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_txd,
   output      logic       rsp_tx_busy,
   output      logic       rsp_rx_valid,
   output      logic [7:0] rsp_rx_data,
   output      logic       rsp_rx_error,
   output      logic       rsp_rx_busy
);

   logic                   bit_top_ff;
   logic [7:0]             bit_top_val_ff;
   logic                   in_valid_ff;
   tsut_pkg::req_item_type in_item_ff;
   logic                   rsp_valid_ff;
   tsut_pkg::rsp_item_type rsp_item_ff;
   tsut_pkg::rsp_item_type core_result;
   logic                   out_free;
   logic                   work_en;
   logic                   req_accept;

   // Timer top register; bit_top_ff marks a write since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_top_ff     <= 1'b0;
         bit_top_val_ff <= tsut_pkg::BIT_TOP_RESET;
      end else if (csr_wr_en) begin
         bit_top_ff     <= 1'b1;
         bit_top_val_ff <= csr_wr_data;
      end
   end

   // Handshake: the input stage moves on when the result register is free.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign work_en    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.rxd       <= req_rxd;
         in_item_ff.tx_load   <= req_tx_load;
         in_item_ff.tx_byte   <= req_tx_byte;
         in_item_ff.rx_take   <= req_rx_take;
         in_item_ff.err_clear <= req_err_clear;
      end
   end

   // UART state and per-tick logic.
   tsut_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (work_en),
      .item    (in_item_ff),
      .bit_top (bit_top_ff ? bit_top_val_ff : tsut_pkg::BIT_TOP_RESET),
      .result  (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (work_en) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_txd      = rsp_item_ff.txd;
   assign rsp_tx_busy  = rsp_item_ff.tx_busy;
   assign rsp_rx_valid = rsp_item_ff.rx_valid;
   assign rsp_rx_data  = rsp_item_ff.rx_data;
   assign rsp_rx_error = rsp_item_ff.rx_error;
   assign rsp_rx_busy  = rsp_item_ff.rx_busy;

endmodule

`default_nettype wire
